// ----- src/mmds_pkg.sv -----
package mmds_pkg;

  // Largest sample count the design is sized for; rank and count fields
  // are wide enough to hold it.
  localparam int MaxSamples = 9;
  localparam int RankW      = $clog2(MaxSamples + 1);

  typedef logic [RankW-1:0] rank_t;

endpackage

// ----- src/mmds_lane.sv -----
// One lane: place of its own sample in the ascending order of valid samples.
// Ties break by lane index, so equal samples still get distinct ranks.
module mmds_lane
  import mmds_pkg::*;
#(
  parameter int SAMPLE_COUNT = 5,
  parameter int DEPTH_WIDTH  = 16,
  parameter int LANE_IDX     = 0
) (
  input  logic [SAMPLE_COUNT*DEPTH_WIDTH-1:0] samples_i,
  input  logic [SAMPLE_COUNT-1:0]             valid_i,
  input  rank_t                               half_i,
  output logic                                hit_o
);

  logic [DEPTH_WIDTH-1:0] own;
  logic [SAMPLE_COUNT-1:0] below;
  rank_t rank;

  assign own = samples_i[LANE_IDX*DEPTH_WIDTH +: DEPTH_WIDTH];

  // independent compares against every other sample
  always_comb begin
    for (int j = 0; j < SAMPLE_COUNT; j++) begin
      if (j == LANE_IDX) begin
        below[j] = 1'b0;
      end else if (j < LANE_IDX) begin
        below[j] = valid_i[j] && (samples_i[j*DEPTH_WIDTH +: DEPTH_WIDTH] <= own);
      end else begin
        below[j] = valid_i[j] && (samples_i[j*DEPTH_WIDTH +: DEPTH_WIDTH] < own);
      end
    end
  end

  always_comb begin
    rank = '0;
    for (int j = 0; j < SAMPLE_COUNT; j++) begin
      rank = rank + rank_t'(below[j]);
    end
  end

  assign hit_o = valid_i[LANE_IDX] && (rank == half_i);

endmodule

// ----- src/mmds_merge.sv -----
// Merge stage: picks the one lane that hit, falls back to the held depth,
// and owns the output register.
module mmds_merge
  import mmds_pkg::*;
#(
  parameter int SAMPLE_COUNT = 5,
  parameter int DEPTH_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s1_vld_i,
  input  logic [SAMPLE_COUNT-1:0]             hit_i,
  input  logic [SAMPLE_COUNT*DEPTH_WIDTH-1:0] samples_i,
  output logic                                adv_o,
  output logic                                out_vld_o,
  input  logic                                out_rdy_i,
  output logic [DEPTH_WIDTH-1:0]              pixel_o,
  output logic                                held_o
);

  logic                   out_vld_r, out_vld_nxt;
  logic [DEPTH_WIDTH-1:0] pixel_r, pixel_nxt;
  logic                   held_r, held_nxt;
  logic [DEPTH_WIDTH-1:0] last_good_r, last_good_nxt;
  logic [DEPTH_WIDTH-1:0] median;
  logic                   load;

  // at most one lane hits, so an OR of gated samples is the mux
  always_comb begin
    median = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      median = median | (samples_i[i*DEPTH_WIDTH +: DEPTH_WIDTH] & {DEPTH_WIDTH{hit_i[i]}});
    end
  end

  assign adv_o = !out_vld_r || out_rdy_i;
  assign load  = adv_o && s1_vld_i;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    pixel_nxt     = pixel_r;
    held_nxt      = held_r;
    last_good_nxt = last_good_r;
    if (adv_o) begin
      out_vld_nxt = s1_vld_i;
    end
    if (load) begin
      if (|hit_i) begin
        pixel_nxt     = median;
        held_nxt      = 1'b0;
        last_good_nxt = median;
      end else begin
        pixel_nxt = last_good_r;
        held_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      last_good_r <= '0;
    end else begin
      out_vld_r   <= out_vld_nxt;
      last_good_r <= last_good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
    held_r  <= held_nxt;
  end

  assign out_vld_o = out_vld_r;
  assign pixel_o   = pixel_r;
  assign held_o    = held_r;

endmodule

// ----- src/masked_median_depth_subsampler.sv -----
// channel | port group        | word contents (lowest bit up)
// --------+-------------------+------------------------------------------------
// input   | in_tvalid/tready  | tdata: sample_a..sample_e; tuser: valid_a..e
// output  | out_tvalid/tready | tdata: pixel_depth (zero padded); tuser: held
//
// Two register stages: one word per cycle sustained while the output is not
// stalled. The lane rank stage ranks all samples in parallel, then the merge
// stage selects and registers.
// Reset (rst_n, synchronous, active low) empties both stages and clears the
// held depth to zero. A stall at the output backs up through both stages;
// input is still taken while the output word waits if stage one is empty.
module masked_median_depth_subsampler
  import mmds_pkg::*;
#(
  parameter int SAMPLE_COUNT = 5,
  parameter int DEPTH_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // sample_a, sample_b, ... each DEPTH_WIDTH bits, zero padded to bytes
  input  logic [((SAMPLE_COUNT*DEPTH_WIDTH+7)/8)*8-1:0] in_tdata,
  // valid_a, valid_b, ... one bit each
  input  logic [SAMPLE_COUNT-1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // pixel_depth, zero padded to bytes
  output logic [((DEPTH_WIDTH+7)/8)*8-1:0] out_tdata,
  // held
  output logic [0:0] out_tuser
);

  localparam int SampW = SAMPLE_COUNT * DEPTH_WIDTH;
  localparam int OutW  = ((DEPTH_WIDTH + 7) / 8) * 8;

  logic [SampW-1:0]        samples;
  logic [SAMPLE_COUNT-1:0] hit;
  rank_t                   n_valid;
  rank_t                   half;

  // stage one registers
  logic                    s1_vld_r, s1_vld_nxt;
  logic [SAMPLE_COUNT-1:0] hit_r;
  logic [SampW-1:0]        samp_r;

  logic                    adv;
  logic [DEPTH_WIDTH-1:0]  pixel;
  logic                    held;

  assign samples = in_tdata[SampW-1:0];

  always_comb begin
    n_valid = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      n_valid = n_valid + rank_t'(in_tuser[i]);
    end
  end

  // upper median index
  assign half = n_valid >> 1;

  for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_lane
    mmds_lane #(
      .SAMPLE_COUNT(SAMPLE_COUNT),
      .DEPTH_WIDTH (DEPTH_WIDTH),
      .LANE_IDX    (g)
    ) u_lane (
      .samples_i(samples),
      .valid_i  (in_tuser),
      .half_i   (half),
      .hit_o    (hit[g])
    );
  end

  assign in_tready = !s1_vld_r || adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      hit_r  <= hit;
      samp_r <= samples;
    end
  end

  mmds_merge #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld_i (s1_vld_r),
    .hit_i    (hit_r),
    .samples_i(samp_r),
    .adv_o    (adv),
    .out_vld_o(out_tvalid),
    .out_rdy_i(out_tready),
    .pixel_o  (pixel),
    .held_o   (held)
  );

  assign out_tdata = OutW'(pixel);
  assign out_tuser = held;

endmodule

// ----- bench/masked_median_depth_subsampler_test.sv -----
`timescale 1ns / 1ps

// Bench for the masked median depth subsampler.
// Each input word carries five depth samples (tdata) and their valid flags
// (tuser). The expected pixel is the element at index n/2 of the n valid
// samples in ascending order. When no sample is valid, the last good depth is
// repeated with held set. Pixels are checked in order against a queue that is
// filled as input words are accepted.
module masked_median_depth_subsampler_test;

  localparam int Samples  = 5;
  localparam int DepthW   = 16;
  localparam int InDataW  = ((Samples * DepthW + 7) / 8) * 8;
  localparam int OutDataW = ((DepthW + 7) / 8) * 8;
  localparam int RandomBlocks = 1080;
  // Cycles without any accepted word before the run is declared hung.
  localparam int QuietLimit = 2000;
  // Length of the forced receiver stall that backs the pipe up.
  localparam int HoldOffCycles = 80;

  typedef logic [Samples-1:0][DepthW-1:0] block_t;
  typedef logic [Samples-1:0]             mask_t;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              held;
  } pixel_t;

  // Scoreboard: keeps its own copy of the last good depth and the pixels
  // still owed by the block.
  class pixel_ledger;
    pixel_t            owed[$];
    logic [DepthW-1:0] last_depth;
    int unsigned       errors;

    function new();
      last_depth = '0;
      errors     = 0;
    endfunction

    // Insertion sort of the valid samples, then pick index n/2.
    function void take_block(block_t s, mask_t mask);
      logic [DepthW-1:0] kept[Samples];
      logic [DepthW-1:0] key;
      int                n;
      int                j;
      pixel_t            px;
      n = 0;
      for (int i = 0; i < Samples; i++) begin
        if (mask[i]) begin
          key = s[i];
          j   = n;
          while (j > 0 && kept[j-1] > key) begin
            kept[j] = kept[j-1];
            j--;
          end
          kept[j] = key;
          n++;
        end
      end
      if (n == 0) begin
        px.depth = last_depth;
        px.held  = 1'b1;
      end else begin
        last_depth = kept[n/2];
        px.depth   = last_depth;
        px.held    = 1'b0;
      end
      owed = {owed, px};
    endfunction

    function void check_pixel(logic [DepthW-1:0] depth, logic held);
      pixel_t want;
      if (owed.size() == 0) begin
        errors++;
        $error("unexpected pixel: pixel_depth %0d, held %0b", depth, held);
        return;
      end
      want = owed.pop_front();
      if (depth !== want.depth) begin
        errors++;
        $error("pixel_depth: expected %0d, got %0d", want.depth, depth);
      end
      if (held !== want.held) begin
        errors++;
        $error("held: expected %0b, got %0b", want.held, held);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // sample_a..sample_e, 16 bits each
  logic [Samples-1:0]  in_tuser;   // valid_a..valid_e
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // pixel_depth
  logic [0:0]          out_tuser;  // held

  pixel_ledger ledger;
  bit          idle_on;       // random gaps on both sides when set
  bit          hold_off_req;  // asks the receiver for one long stall
  int unsigned quiet_cycles;

  masked_median_depth_subsampler #(
    .SAMPLE_COUNT(Samples),
    .DEPTH_WIDTH (DepthW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers update. Input words go to the ledger first; a pixel can never
  // leave in the same cycle its word is taken (two register stages).
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        ledger.take_block(in_tdata[Samples*DepthW-1:0], in_tuser);
      if (out_tvalid && out_tready)
        ledger.check_pixel(out_tdata[DepthW-1:0], out_tuser[0]);
    end
    // Hang watchdog: counts cycles in which neither side moves a word.
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver. Drives tready at the falling edge; a hold-off request holds
  // it low for one long stall while the sender keeps pushing.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 11);
      end
    end
  end

  // Offers one word; called at a falling edge and returns at a falling edge
  // after the word is taken, with tvalid still high for the next call.
  task automatic push_block(input block_t s, input mask_t mask);
    if (idle_on && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InDataW'(s);
    in_tuser  <= mask;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix of full-range depths, tiny ranges (many duplicates) and extremes.
  function automatic logic [DepthW-1:0] pick_depth();
    case ($urandom_range(3))
      0, 1:    pick_depth = DepthW'($urandom);
      2:       pick_depth = DepthW'($urandom_range(7));
      default: pick_depth = $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  initial begin
    block_t s;
    mask_t  mask;

    ledger       = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // nothing valid straight after reset: held zero
    push_block({16'd11, 16'd22, 16'd33, 16'd44, 16'd55}, 5'b00000);
    // single valid sample at each position
    push_block({16'd5, 16'd4, 16'd3, 16'd2, 16'd1}, 5'b00001);
    push_block({16'd5, 16'd4, 16'd3, 16'd2, 16'd1}, 5'b00010);
    push_block({16'd5, 16'd4, 16'd3, 16'd2, 16'd1}, 5'b00100);
    push_block({16'd5, 16'd4, 16'd3, 16'd2, 16'd1}, 5'b01000);
    push_block({16'd5, 16'd4, 16'd3, 16'd2, 16'd1}, 5'b10000);
    // field extremes
    push_block({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 5'b11111);
    push_block({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 5'b11111);
    push_block({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 5'b11111);
    // nothing valid: holds the previous median, not zero
    push_block({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 5'b11111);
    push_block({16'd1, 16'd2, 16'd3, 16'd4, 16'd5}, 5'b00000);
    push_block({16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 5'b00000);
    // even and odd counts; even counts take the upper median
    push_block({16'd900, 16'd100, 16'd700, 16'd300, 16'd500}, 5'b00011);
    push_block({16'd900, 16'd100, 16'd700, 16'd300, 16'd500}, 5'b11110);
    push_block({16'd900, 16'd100, 16'd700, 16'd300, 16'd500}, 5'b10101);
    // descending and shuffled full sets
    push_block({16'd10, 16'd20, 16'd30, 16'd40, 16'd50}, 5'b11111);
    push_block({16'd40, 16'd10, 16'd50, 16'd20, 16'd30}, 5'b11111);
    // duplicates count separately
    push_block({16'd7, 16'd7, 16'd3, 16'd7, 16'd3}, 5'b11111);
    push_block({16'd9, 16'd2, 16'd2, 16'd9, 16'd2}, 5'b01111);
    push_block({16'd6, 16'd6, 16'd6, 16'd6, 16'd6}, 5'b11011);
    // masked-out samples must not leak into the order
    push_block({16'hFFFF, 16'd12, 16'hFFFF, 16'd10, 16'd0}, 5'b01010);

    // Random part. The middle stretch runs with no gaps on either side;
    // two long receiver stalls fill the pipe and block the input.
    for (int k = 0; k < RandomBlocks; k++) begin
      idle_on = !(k >= 400 && k < 700);
      if (k == 150 || k == 850)
        hold_off_req = 1'b1;
      for (int i = 0; i < Samples; i++)
        s[i] = pick_depth();
      // occasional runs of all-missing samples exercise the hold path
      mask = ($urandom_range(99) < 8) ? '0 : mask_t'($urandom);
      push_block(s, mask);
    end
    in_tvalid <= 1'b0;

    // Drain, then give the two stages time to show any stray pixel.
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
src/mmds_pkg.sv
src/mmds_lane.sv
src/mmds_merge.sv
src/masked_median_depth_subsampler.sv
bench/masked_median_depth_subsampler_test.sv
